[rtl/wcs_pkg.sv]
package wcs_pkg;

	localparam int MAX_CELLS_DEF = 4096;

	localparam int COORD_W   = 32;
	localparam int INT_W     = 17;
	localparam int DRAW_W    = 16;
	localparam int HALF_W    = 16;
	localparam int CHOSEN_W  = 12;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	// full weight, i.e. 1.0 in units of 1/65536
	localparam logic [INT_W-1:0] FULL_WEIGHT = 17'h10000;
	localparam logic [INT_W-1:0] BIAS_RESET  = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_CELL      = 4'd1;

	// one table row: x, y, weight
	localparam int ROW_W = 2 * COORD_W + INT_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_LOAD   = 2'd1,
		REQ_SAMPLE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_SCAN,
		S_UREAD,
		S_USEL,
		S_JIT,
		S_SUM,
		S_OUT
	} state_t;

endpackage

[rtl/wcs_ram.sv]
module wcs_ram #(
	parameter int WIDTH = wcs_pkg::ROW_W,
	parameter int DEPTH = wcs_pkg::MAX_CELLS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/weighted_cell_sampler.sv]
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------------
// request  | req_valid / req_stall | req_type, cell_x, cell_y, cell_intensity, draws
// response | rsp_valid / rsp_stall | sample_x, sample_y, chosen_cell, was_uniform, status
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data (ready is always high)
//
// Clear gives no response; a weighted sample walks up to cell_count table rows:
// the cumulative walk reads one table row per cycle from the cell RAM.
// One item is in work at a time; a new item is taken while a result waits at the output.
// The result waits in its final state while an earlier response is held by rsp_stall.
// Reset clears count, weight sum and state; table rows are undefined until loaded.
module weighted_cell_sampler #(
	parameter int MAX_CELLS = wcs_pkg::MAX_CELLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [wcs_pkg::REQ_W-1:0]            req_type,
	input  logic signed [wcs_pkg::COORD_W-1:0]   cell_x,
	input  logic signed [wcs_pkg::COORD_W-1:0]   cell_y,
	input  logic [wcs_pkg::INT_W-1:0]            cell_intensity,
	input  logic [wcs_pkg::DRAW_W-1:0]           bias_draw,
	input  logic [wcs_pkg::DRAW_W-1:0]           pick_draw,
	input  logic [wcs_pkg::DRAW_W-1:0]           jitter_x_draw,
	input  logic [wcs_pkg::DRAW_W-1:0]           jitter_y_draw,

	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [wcs_pkg::COORD_W-1:0]   sample_x,
	output logic signed [wcs_pkg::COORD_W-1:0]   sample_y,
	output logic [wcs_pkg::CHOSEN_W-1:0]         chosen_cell,
	output logic                                 was_uniform,
	output logic [wcs_pkg::STATUS_W-1:0]         status,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wcs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int TW = CW + wcs_pkg::DRAW_W;
	localparam int XW = wcs_pkg::COORD_W;
	localparam int IW = wcs_pkg::INT_W;
	localparam int DW = wcs_pkg::DRAW_W;
	localparam int HW = wcs_pkg::HALF_W;
	localparam int OW = HW + 1;            // width of jitter offset
	localparam int SW = XW + 2;            // width of jitter sum
	localparam int RW = wcs_pkg::ROW_W;

	function automatic logic [XW-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic [XW-1:0] r;
		if (v[SW-1:XW-1] == {(SW-XW+1){1'b0}} || v[SW-1:XW-1] == {(SW-XW+1){1'b1}}) begin
			r = v[XW-1:0];
		end else if (v[SW-1]) begin
			r = {1'b1, {(XW-1){1'b0}}};
		end else begin
			r = {1'b0, {(XW-1){1'b1}}};
		end
		return r;
	endfunction

	wcs_pkg::state_t state_q, state_d;

	logic [IW-1:0]   bias_threshold_q;
	logic [HW-1:0]   half_cell_q;
	logic [CW-1:0]   cell_count_q;
	logic [TW-1:0]   weight_total_q;

	logic [DW-1:0]   pick_q, jx_q, jy_q;
	logic            uni_q;
	logic [TW-1:0]   target_q;
	logic [TW-1:0]   acc_q;
	logic [CW-1:0]   scan_addr_q;
	logic            rd_vld_s1;
	logic [CW-1:0]   rd_idx_s1;
	logic [AW-1:0]   chosen_q;
	logic [XW-1:0]   cx_q, cy_q;
	logic [OW-1:0]   offx_q, offy_q;

	logic [XW-1:0]   res_x_q, res_y_q;
	logic [AW-1:0]   res_idx_q;
	logic            res_uni_q;
	logic [wcs_pkg::STATUS_W-1:0] res_status_q;

	logic            rsp_valid_q;
	logic [XW-1:0]   sample_x_q, sample_y_q;
	logic [wcs_pkg::CHOSEN_W-1:0] chosen_cell_q;
	logic            was_uniform_q;
	logic [wcs_pkg::STATUS_W-1:0] status_q;

	logic            accept, out_free, table_full, hit;
	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [RW-1:0]   ram_wdata, ram_rdata;
	logic [IW-1:0]   new_weight;
	logic [TW-1:0]   calc_opnd;
	logic [DW+TW-1:0] calc_prod;
	logic [TW-1:0]   acc_nx;
	logic [XW-1:0]   rd_x, rd_y;
	logic [IW-1:0]   rd_w;
	logic [DW+OW-1:0] jprod_x, jprod_y;
	logic signed [SW-1:0] sum_x, sum_y;

	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign table_full = cell_count_q >= CW'(MAX_CELLS);
	assign cfg_ready  = 1'b1;

	assign new_weight = (cell_intensity >= wcs_pkg::FULL_WEIGHT) ? '0
		: IW'(wcs_pkg::FULL_WEIGHT - cell_intensity);
	assign ram_wdata  = {cell_x, cell_y, new_weight};

	assign rd_x = ram_rdata[RW-1 -: XW];
	assign rd_y = ram_rdata[RW-XW-1 -: XW];
	assign rd_w = ram_rdata[IW-1:0];

	assign calc_opnd = uni_q ? TW'(cell_count_q) : weight_total_q;
	assign calc_prod = pick_q * calc_opnd;

	assign acc_nx = acc_q + TW'(rd_w);
	// last row is taken when no cumulative weight passes the target
	assign hit = rd_vld_s1 && (acc_nx > target_q || rd_idx_s1 == cell_count_q - CW'(1));

	assign jprod_x = jx_q * {half_cell_q, 1'b0};
	assign jprod_y = jy_q * {half_cell_q, 1'b0};

	assign sum_x = $signed({{2{cx_q[XW-1]}}, cx_q}) - $signed({{(SW-HW){1'b0}}, half_cell_q})
		+ $signed({{(SW-OW){1'b0}}, offx_q});
	assign sum_y = $signed({{2{cy_q[XW-1]}}, cy_q}) - $signed({{(SW-HW){1'b0}}, half_cell_q})
		+ $signed({{(SW-OW){1'b0}}, offy_q});

	wcs_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cell_count_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wcs_pkg::S_IDLE: begin
				if (accept) begin
					if (req_type == wcs_pkg::REQ_LOAD) begin
						state_d = wcs_pkg::S_OUT;
					end else if (req_type == wcs_pkg::REQ_SAMPLE) begin
						state_d = (cell_count_q == '0) ? wcs_pkg::S_OUT : wcs_pkg::S_CALC;
					end
				end
			end
			wcs_pkg::S_CALC:  state_d = uni_q ? wcs_pkg::S_UREAD : wcs_pkg::S_SCAN;
			wcs_pkg::S_SCAN: begin
				if (hit) begin
					state_d = wcs_pkg::S_JIT;
				end
			end
			wcs_pkg::S_UREAD: state_d = wcs_pkg::S_USEL;
			wcs_pkg::S_USEL:  state_d = wcs_pkg::S_JIT;
			wcs_pkg::S_JIT:   state_d = wcs_pkg::S_SUM;
			wcs_pkg::S_SUM:   state_d = wcs_pkg::S_OUT;
			wcs_pkg::S_OUT: begin
				if (out_free) begin
					state_d = wcs_pkg::S_IDLE;
				end
			end
			default: state_d = wcs_pkg::S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_raddr = scan_addr_q[AW-1:0];
		case (state_q)
			wcs_pkg::S_IDLE: begin
				req_stall = 1'b0;
				ram_we    = req_valid && req_type == wcs_pkg::REQ_LOAD && !table_full;
			end
			wcs_pkg::S_UREAD: ram_raddr = target_q[AW-1:0];
			default: begin
				ram_raddr = scan_addr_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= wcs_pkg::S_IDLE;
			bias_threshold_q <= wcs_pkg::BIAS_RESET;
			half_cell_q      <= '0;
			cell_count_q     <= '0;
			weight_total_q   <= '0;
			rd_vld_s1        <= 1'b0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == wcs_pkg::S_SCAN);

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wcs_pkg::CFG_BIAS_THRESHOLD: bias_threshold_q <= cfg_data[IW-1:0];
					wcs_pkg::CFG_HALF_CELL:      half_cell_q      <= cfg_data[HW-1:0];
					default: ;
				endcase
			end

			if (accept && req_type == wcs_pkg::REQ_CLEAR) begin
				cell_count_q   <= '0;
				weight_total_q <= '0;
			end else if (ram_we) begin
				cell_count_q   <= cell_count_q + CW'(1);
				weight_total_q <= weight_total_q + TW'(new_weight);
			end

			if (state_q == wcs_pkg::S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			wcs_pkg::S_IDLE: begin
				pick_q       <= pick_draw;
				jx_q         <= jitter_x_draw;
				jy_q         <= jitter_y_draw;
				uni_q        <= !({1'b0, bias_draw} < bias_threshold_q);
				res_x_q      <= '0;
				res_y_q      <= '0;
				res_idx_q    <= '0;
				res_uni_q    <= 1'b0;
				if (req_type == wcs_pkg::REQ_LOAD) begin
					res_status_q <= table_full ? wcs_pkg::ST_FULL : wcs_pkg::ST_OK;
				end else begin
					res_status_q <= wcs_pkg::ST_EMPTY;
				end
			end
			wcs_pkg::S_CALC: begin
				target_q    <= TW'(calc_prod >> DW);
				acc_q       <= '0;
				scan_addr_q <= '0;
			end
			wcs_pkg::S_SCAN: begin
				scan_addr_q <= scan_addr_q + CW'(1);
				rd_idx_s1   <= scan_addr_q;
				if (rd_vld_s1) begin
					acc_q <= acc_nx;
				end
				if (hit) begin
					chosen_q <= rd_idx_s1[AW-1:0];
					cx_q     <= rd_x;
					cy_q     <= rd_y;
				end
			end
			wcs_pkg::S_USEL: begin
				chosen_q <= target_q[AW-1:0];
				cx_q     <= rd_x;
				cy_q     <= rd_y;
			end
			wcs_pkg::S_JIT: begin
				offx_q <= OW'(jprod_x >> DW);
				offy_q <= OW'(jprod_y >> DW);
			end
			wcs_pkg::S_SUM: begin
				res_x_q      <= sat_coord(sum_x);
				res_y_q      <= sat_coord(sum_y);
				res_idx_q    <= chosen_q;
				res_uni_q    <= uni_q;
				res_status_q <= wcs_pkg::ST_OK;
			end
			wcs_pkg::S_OUT: begin
				if (out_free) begin
					sample_x_q    <= res_x_q;
					sample_y_q    <= res_y_q;
					chosen_cell_q <= wcs_pkg::CHOSEN_W'(res_idx_q);
					was_uniform_q <= res_uni_q;
					status_q      <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign sample_x    = sample_x_q;
	assign sample_y    = sample_y_q;
	assign chosen_cell = chosen_cell_q;
	assign was_uniform = was_uniform_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cell_count_q <= CW'(MAX_CELLS))
		else $error("cell count beyond table depth");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_count_q == '0) |-> (weight_total_q == '0))
		else $error("weight sum nonzero with empty table");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wcs_pkg::S_SCAN && rd_vld_s1) |-> (rd_idx_s1 < cell_count_q))
		else $error("scan read past loaded cells");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cell_count_q < CW'(MAX_CELLS)))
		else $error("table write while full");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == wcs_pkg::S_OUT))
		else $error("response raised outside output state");
`endif

endmodule
